/* rtl/core/lzosd_pkg.sv */
// Shared types and constants for the LZO1X stream decompressor.
// No dependencies; every other file of the block except lzosd_if refers to this package.
package lzosd_pkg;

  // Default window size and length width.
  localparam int unsigned HISTORY_BYTES_DEF = 65536;
  localparam int unsigned LENGTH_BITS_DEF   = 24;

  // Depth of the command queue between the parser and the copy engine.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Opcode and distance constants of the format.
  localparam logic [7:0]  FIRST_LIT_BIAS = 8'd17;
  localparam logic [7:0]  EXT_STEP       = 8'd255;
  localparam logic [5:0]  M3_LEN_BASE    = 6'd31;
  localparam logic [5:0]  M4_LEN_BASE    = 6'd7;
  localparam logic [16:0] M1_FAR_BASE    = 17'h0801;
  localparam logic [16:0] M4_DIST_BASE   = 17'h4000;
  localparam logic [14:0] M4_FAR_STEP    = 15'h4000;
  localparam logic [2:0]  HEADER_BYTES   = 3'd4;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_FIRST      = 4'd1,
    PH_CMD_TOP    = 4'd2,
    PH_CMD_MATCH  = 4'd3,
    PH_RUN_EXT    = 4'd4,
    PH_LITERALS   = 4'd5,
    PH_LEN_EXT    = 4'd6,
    PH_DIST_LO    = 4'd7,
    PH_DIST_HI    = 4'd8,
    PH_SHORT_DIST = 4'd9,
    PH_COPY       = 4'd10
  } phase_t;

  // Error codes reported with each result.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BUSY     = 2'd1,
    ERR_DISTANCE = 2'd2,
    ERR_LENGTH   = 2'd3
  } err_t;

  // Control part of one command from the parser to the copy engine.
  typedef struct packed {
    logic wr;       // a byte is produced and written to history
    logic lit;      // the byte is a literal, not a history read
    logic pending;  // match bytes remain after this item
    logic done;     // end marker completed by this item
    err_t err;
  } cmd_ctl_t;

endpackage

/* rtl/core/lzosd_if.sv */
// Handshake channel interfaces of the LZO1X stream decompressor.
// Depends on nothing; the error code is carried as a plain two-bit vector.
interface lzosd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;
  modport source (output valid, output op, output in_byte, input ready);
  modport sink (input valid, input op, input in_byte, output ready);
endinterface

interface lzosd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       copy_pending;
  logic       stream_end;
  logic [1:0] error_code;
  modport source (output valid, output out_valid, output out_byte, output copy_pending,
                  output stream_end, output error_code, input ready);
  modport sink (input valid, input out_valid, input out_byte, input copy_pending,
                input stream_end, input error_code, output ready);
endinterface

/* rtl/core/lzo1x_stream_decompressor_core.sv */
// Top level of the LZO1X stream decompressor: parser, command queue, copy engine.
// Depends on lzosd_pkg, lzosd_if, lzosd_front, lzosd_queue and lzosd_back.
//
//   channel | dir | payload                                            | handshake
//   in_ch   | in  | op, in_byte                                        | valid/ready
//   out_ch  | out | out_valid, out_byte, copy_pending, stream_end,     | valid/ready
//           |     | error_code                                         |
//
// Every item gives one result; one item per cycle is sustained while out_ch.ready is high.
// The parser decodes in the accept cycle; the command is registered in the queue, then
// the history memory read with its registered output fills the result stage.
// Reset (synchronous, active low) empties the queue and result stage; history is not cleared.
// A stalled output fills the queue of four commands, then in_ch.ready drops.
module lzo1x_stream_decompressor_core #(
  parameter int unsigned HISTORY_BYTES = lzosd_pkg::HISTORY_BYTES_DEF,
  parameter int unsigned LENGTH_BITS   = lzosd_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  lzosd_in_if.sink     in_ch,
  lzosd_out_if.source  out_ch
);

  localparam int unsigned AW  = $clog2(HISTORY_BYTES);
  localparam int unsigned CTW = $bits(lzosd_pkg::cmd_ctl_t);
  localparam int unsigned QW  = CTW + 8 + 2 * AW;

  logic                accept;
  logic                not_full;
  logic                pop;
  logic                head_valid;
  logic [QW-1:0]       head_vec;
  lzosd_pkg::cmd_ctl_t cmd_ctl;
  logic [7:0]          cmd_data;
  logic [AW-1:0]       cmd_raddr;
  logic [AW-1:0]       cmd_waddr;
  lzosd_pkg::cmd_ctl_t head_ctl;
  logic [7:0]          head_data;
  logic [AW-1:0]       head_raddr;
  logic [AW-1:0]       head_waddr;
  lzosd_pkg::cmd_ctl_t res_ctl;

  assign in_ch.ready = not_full;
  assign accept      = in_ch.valid && not_full;

  // Parser.
  lzosd_front #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_ch.op),
    .in_byte   (in_ch.in_byte),
    .cmd_ctl   (cmd_ctl),
    .cmd_data  (cmd_data),
    .cmd_raddr (cmd_raddr),
    .cmd_waddr (cmd_waddr)
  );

  // Command queue.
  lzosd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  ({cmd_ctl, cmd_data, cmd_raddr, cmd_waddr}),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_vec)
  );

  assign {head_ctl, head_data, head_raddr, head_waddr} = head_vec;

  // Copy engine.
  lzosd_back #(
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_data  (head_data),
    .head_raddr (head_raddr),
    .head_waddr (head_waddr),
    .pop        (pop),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_ctl    (res_ctl),
    .res_byte   (out_ch.out_byte)
  );

  assign out_ch.out_valid    = res_ctl.wr;
  assign out_ch.copy_pending = res_ctl.pending;
  assign out_ch.stream_end   = res_ctl.done;
  assign out_ch.error_code   = res_ctl.err;

endmodule

/* rtl/core/lzosd_front.sv */
// Parser of the decompressor: decodes one byte or tick per cycle into a command, while accept is high.
// Depends on lzosd_pkg; tracks write position and produced count of the window.
module lzosd_front #(
  parameter int unsigned HISTORY_BYTES = lzosd_pkg::HISTORY_BYTES_DEF,
  parameter int unsigned LENGTH_BITS   = lzosd_pkg::LENGTH_BITS_DEF,
  localparam int unsigned AW = $clog2(HISTORY_BYTES),
  localparam int unsigned PW = AW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                op,
  input  logic [7:0]          in_byte,
  output lzosd_pkg::cmd_ctl_t cmd_ctl,
  output logic [7:0]          cmd_data,
  output logic [AW-1:0]       cmd_raddr,
  output logic [AW-1:0]       cmd_waddr
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [PW-1:0] WIN_FULL = PW'(HISTORY_BYTES);

  lzosd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]             hdr_r, hdr_nxt;
  logic [7:0]             instr_r, instr_nxt;
  logic [7:0]             dlo_r, dlo_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] lit_r, lit_nxt;
  logic [LENGTH_BITS-1:0] copy_r, copy_nxt;
  logic [PW-1:0]          cdist_r, cdist_nxt;
  logic [1:0]             trail_r, trail_nxt;
  logic                   after_r, after_nxt;
  logic [AW-1:0]          wpos_r, wpos_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;

  // Saturating length add; the top bit flags saturation.
  function automatic logic [LENGTH_BITS:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                   input logic [9:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(b);
    if (s[LENGTH_BITS]) begin
      s = {1'b1, LEN_MAX};
    end
    return s;
  endfunction

  // Decode of one item.
  always_comb begin
    logic [LENGTH_BITS:0] sum;
    logic                 do_match;
    logic                 do_begin;
    logic                 do_after;
    logic [16:0]          bc_dist;
    logic [LENGTH_BITS-1:0] bc_len;
    logic [PW-1:0]        bc_dist_w;
    logic [13:0]          d;
    logic [14:0]          far;
    logic [7:0]           t;

    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    instr_nxt = instr_r;
    dlo_nxt   = dlo_r;
    acc_nxt   = acc_r;
    lit_nxt   = lit_r;
    copy_nxt  = copy_r;
    cdist_nxt = cdist_r;
    trail_nxt = trail_r;
    after_nxt = after_r;
    wpos_nxt  = wpos_r;
    prod_nxt  = prod_r;
    cmd_ctl   = '0;
    cmd_data  = '0;
    cmd_raddr = wpos_r - cdist_r[AW-1:0];
    cmd_waddr = wpos_r;
    sum       = '0;
    do_match  = 1'b0;
    do_begin  = 1'b0;
    do_after  = 1'b0;
    bc_dist   = '0;
    bc_len    = '0;
    bc_dist_w = '0;
    d         = {in_byte, dlo_r[7:2]};
    far       = (instr_r[3] ? lzosd_pkg::M4_FAR_STEP : 15'd0) + {1'b0, d};
    t         = instr_r;

    if (op) begin
      // Tick: copy one match byte from history.
      if (phase_r == lzosd_pkg::PH_COPY) begin
        cmd_ctl.wr = 1'b1;
        wpos_nxt   = wpos_r + 1'b1;
        if (prod_r < WIN_FULL) begin
          prod_nxt = prod_r + 1'b1;
        end
        copy_nxt = copy_r - 1'b1;
        if (copy_nxt == '0) begin
          do_after = 1'b1;
        end
      end
    end else begin
      unique case (phase_r)
        lzosd_pkg::PH_HEADER: begin
          if (hdr_r != '0) begin
            hdr_nxt = hdr_r - 1'b1;
          end
          if (hdr_nxt == '0) begin
            phase_nxt = lzosd_pkg::PH_FIRST;
          end
        end
        lzosd_pkg::PH_FIRST: begin
          if (in_byte > lzosd_pkg::FIRST_LIT_BIAS) begin
            lit_nxt   = LENGTH_BITS'(in_byte - lzosd_pkg::FIRST_LIT_BIAS);
            after_nxt = (lit_nxt >= LENGTH_BITS'(4));
            phase_nxt = lzosd_pkg::PH_LITERALS;
          end else begin
            do_match = 1'b1;
          end
        end
        lzosd_pkg::PH_CMD_TOP: begin
          do_match = 1'b1;
        end
        lzosd_pkg::PH_CMD_MATCH: begin
          do_match = 1'b1;
        end
        lzosd_pkg::PH_RUN_EXT: begin
          if (in_byte == '0) begin
            sum     = sat_add(acc_r, {2'b0, lzosd_pkg::EXT_STEP});
            acc_nxt = sum[LENGTH_BITS-1:0];
          end else begin
            sum       = sat_add(acc_r, {2'b0, in_byte} + 10'd18);
            lit_nxt   = sum[LENGTH_BITS-1:0];
            after_nxt = 1'b1;
            phase_nxt = lzosd_pkg::PH_LITERALS;
          end
          if (sum[LENGTH_BITS]) begin
            cmd_ctl.err = lzosd_pkg::ERR_LENGTH;
          end
        end
        lzosd_pkg::PH_LITERALS: begin
          cmd_ctl.wr  = 1'b1;
          cmd_ctl.lit = 1'b1;
          cmd_data    = in_byte;
          wpos_nxt    = wpos_r + 1'b1;
          if (prod_r < WIN_FULL) begin
            prod_nxt = prod_r + 1'b1;
          end
          if (lit_r != '0) begin
            lit_nxt = lit_r - 1'b1;
          end
          if (lit_nxt == '0) begin
            phase_nxt = lzosd_pkg::PH_CMD_MATCH;
          end
        end
        lzosd_pkg::PH_LEN_EXT: begin
          if (in_byte == '0) begin
            sum     = sat_add(acc_r, {2'b0, lzosd_pkg::EXT_STEP});
            acc_nxt = sum[LENGTH_BITS-1:0];
          end else begin
            sum = sat_add(acc_r, {2'b0, in_byte} + 10'd2 +
                  {4'b0, (instr_r >= 8'd32) ? lzosd_pkg::M3_LEN_BASE : lzosd_pkg::M4_LEN_BASE});
            acc_nxt   = sum[LENGTH_BITS-1:0];
            phase_nxt = lzosd_pkg::PH_DIST_LO;
          end
          if (sum[LENGTH_BITS]) begin
            cmd_ctl.err = lzosd_pkg::ERR_LENGTH;
          end
        end
        lzosd_pkg::PH_DIST_LO: begin
          dlo_nxt   = in_byte;
          trail_nxt = in_byte[1:0];
          phase_nxt = lzosd_pkg::PH_DIST_HI;
        end
        lzosd_pkg::PH_DIST_HI: begin
          if (instr_r >= 8'd32) begin
            do_begin = 1'b1;
            bc_dist  = 17'd1 + {3'b0, d};
            bc_len   = acc_r;
          end else if (far == '0) begin
            // End marker: wait for the header of the next stream.
            cmd_ctl.done = 1'b1;
            phase_nxt    = lzosd_pkg::PH_HEADER;
            hdr_nxt      = lzosd_pkg::HEADER_BYTES;
            prod_nxt     = '0;
            lit_nxt      = '0;
            copy_nxt     = '0;
            trail_nxt    = '0;
            after_nxt    = 1'b0;
          end else begin
            do_begin = 1'b1;
            bc_dist  = {2'b0, far} + lzosd_pkg::M4_DIST_BASE;
            bc_len   = acc_r;
          end
        end
        lzosd_pkg::PH_SHORT_DIST: begin
          trail_nxt = t[1:0];
          do_begin  = 1'b1;
          if (t >= 8'd64) begin
            bc_dist = 17'd1 + {14'b0, t[4:2]} + {6'b0, in_byte, 3'b0};
            bc_len  = LENGTH_BITS'(t[7:5]) + 1'b1;
          end else if (after_r) begin
            bc_dist = lzosd_pkg::M1_FAR_BASE + {11'b0, t[7:2]} + {7'b0, in_byte, 2'b0};
            bc_len  = LENGTH_BITS'(3);
          end else begin
            bc_dist = 17'd1 + {11'b0, t[7:2]} + {7'b0, in_byte, 2'b0};
            bc_len  = LENGTH_BITS'(2);
          end
        end
        lzosd_pkg::PH_COPY: begin
          cmd_ctl.err = lzosd_pkg::ERR_BUSY;
        end
        default: begin
          phase_nxt = lzosd_pkg::PH_HEADER;
          hdr_nxt   = lzosd_pkg::HEADER_BYTES;
        end
      endcase
    end

    // Opcode byte at the top of an instruction.
    if (do_match) begin
      if (in_byte >= 8'd16) begin
        instr_nxt = in_byte;
        if (in_byte >= 8'd64) begin
          phase_nxt = lzosd_pkg::PH_SHORT_DIST;
        end else if (in_byte >= 8'd32) begin
          if (in_byte[4:0] == '0) begin
            acc_nxt   = '0;
            phase_nxt = lzosd_pkg::PH_LEN_EXT;
          end else begin
            acc_nxt   = LENGTH_BITS'(in_byte[4:0]) + LENGTH_BITS'(2);
            phase_nxt = lzosd_pkg::PH_DIST_LO;
          end
        end else if (in_byte[2:0] == '0) begin
          acc_nxt   = '0;
          phase_nxt = lzosd_pkg::PH_LEN_EXT;
        end else begin
          acc_nxt   = LENGTH_BITS'(in_byte[2:0]) + LENGTH_BITS'(2);
          phase_nxt = lzosd_pkg::PH_DIST_LO;
        end
      end else if (phase_r == lzosd_pkg::PH_CMD_MATCH) begin
        instr_nxt = in_byte;
        phase_nxt = lzosd_pkg::PH_SHORT_DIST;
      end else if (in_byte == '0) begin
        acc_nxt   = '0;
        phase_nxt = lzosd_pkg::PH_RUN_EXT;
      end else begin
        lit_nxt   = LENGTH_BITS'(in_byte) + LENGTH_BITS'(3);
        after_nxt = 1'b1;
        phase_nxt = lzosd_pkg::PH_LITERALS;
      end
    end

    // Start of a match copy, checked against the bytes produced so far.
    if (do_begin) begin
      bc_dist_w = PW'(bc_dist);
      if (bc_dist == '0 || bc_dist_w > prod_r) begin
        cmd_ctl.err = lzosd_pkg::ERR_DISTANCE;
        do_after    = 1'b1;
      end else if (bc_len == '0) begin
        do_after = 1'b1;
      end else begin
        cdist_nxt = bc_dist_w;
        copy_nxt  = bc_len;
        phase_nxt = lzosd_pkg::PH_COPY;
      end
    end

    // Trailing literals, if any, follow a match.
    if (do_after) begin
      if (trail_nxt != '0) begin
        lit_nxt   = LENGTH_BITS'(trail_nxt);
        after_nxt = 1'b0;
        phase_nxt = lzosd_pkg::PH_LITERALS;
      end else begin
        phase_nxt = lzosd_pkg::PH_CMD_TOP;
      end
    end

    cmd_ctl.pending = (phase_nxt == lzosd_pkg::PH_COPY);
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lzosd_pkg::PH_HEADER;
      hdr_r   <= lzosd_pkg::HEADER_BYTES;
      instr_r <= '0;
      dlo_r   <= '0;
      acc_r   <= '0;
      lit_r   <= '0;
      copy_r  <= '0;
      cdist_r <= '0;
      trail_r <= '0;
      after_r <= 1'b0;
      wpos_r  <= '0;
      prod_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      instr_r <= instr_nxt;
      dlo_r   <= dlo_nxt;
      acc_r   <= acc_nxt;
      lit_r   <= lit_nxt;
      copy_r  <= copy_nxt;
      cdist_r <= cdist_nxt;
      trail_r <= trail_nxt;
      after_r <= after_nxt;
      wpos_r  <= wpos_nxt;
      prod_r  <= prod_nxt;
    end
  end

endmodule

/* rtl/core/lzosd_queue.sv */
// Short command queue between the parser and the copy engine.
// Depends on lzosd_pkg for its depth; the payload is a flat vector.
module lzosd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int unsigned PTR_W = $clog2(lzosd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] slot_r [lzosd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign not_full   = (count_r != CNT_W'(lzosd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lzosd_back.sv */
// Copy engine: history window memory, read stage and result register.
// Depends on lzosd_pkg; takes commands from the queue head.
module lzosd_back #(
  parameter int unsigned HISTORY_BYTES = lzosd_pkg::HISTORY_BYTES_DEF,
  localparam int unsigned AW = $clog2(HISTORY_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  lzosd_pkg::cmd_ctl_t head_ctl,
  input  logic [7:0]          head_data,
  input  logic [AW-1:0]       head_raddr,
  input  logic [AW-1:0]       head_waddr,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output lzosd_pkg::cmd_ctl_t res_ctl,
  output logic [7:0]          res_byte
);

  logic [7:0]          mem [HISTORY_BYTES];
  logic [7:0]          mem_q_r;
  logic                b_valid_r;
  lzosd_pkg::cmd_ctl_t b_ctl_r;
  logic [7:0]          b_data_r;
  logic [AW-1:0]       b_waddr_r;
  logic                b_fwd_r;
  logic [7:0]          b_fwd_data_r;
  logic                leave;
  logic                fwd;
  logic [7:0]          b_byte;

  // The result leaves when taken; a new command enters behind it.
  assign leave = b_valid_r && res_ready;
  assign pop   = head_valid && (!b_valid_r || res_ready);

  // Byte of the result: literal, byte written on the same edge as the read, or history.
  assign b_byte = b_ctl_r.lit ? b_data_r : (b_fwd_r ? b_fwd_data_r : mem_q_r);
  assign fwd    = leave && b_ctl_r.wr && (b_waddr_r == head_raddr);

  assign res_valid = b_valid_r;
  assign res_ctl   = b_ctl_r;
  assign res_byte  = b_ctl_r.wr ? b_byte : 8'd0;

  // History window: written as results leave, read as commands enter.
  always_ff @(posedge clk) begin
    if (leave && b_ctl_r.wr) begin
      mem[b_waddr_r] <= b_byte;
    end
    if (pop) begin
      mem_q_r <= mem[head_raddr];
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      b_ctl_r      <= head_ctl;
      b_data_r     <= head_data;
      b_waddr_r    <= head_waddr;
      b_fwd_r      <= fwd;
      b_fwd_data_r <= b_byte;
    end
  end

  // Result stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (pop) begin
      b_valid_r <= 1'b1;
    end else if (leave) begin
      b_valid_r <= 1'b0;
    end
  end

endmodule
